@@ sv/frls_pkg.sv @@
`timescale 1ns / 1ps

package frls_pkg;

  localparam int SLOT_COUNT_DEF = 512;

  localparam int NODE_W    = 16;
  localparam int HEADING_W = 8;
  localparam int MAGIC_W   = 32;
  localparam int SLOT_W    = 9;

  localparam logic ACT_SAVE = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // One stored record, as it sits in a memory word.
  typedef struct packed {
    logic [MAGIC_W-1:0]   magic;
    logic [NODE_W-1:0]    node;
    logic [HEADING_W-1:0] heading;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic                 found;
    logic [NODE_W-1:0]    node_out;
    logic [HEADING_W-1:0] heading_out;
    logic [SLOT_W-1:0]    slot_index;
    logic                 sector_erased;
  } res_t;

  // The reported slot number is the slot index masked to the result width.
  function automatic logic [SLOT_W-1:0] slot_tag(input logic [31:0] slot);
    return slot[SLOT_W-1:0];
  endfunction

endpackage

@@ sv/frls_ram.sv @@
`timescale 1ns / 1ps

module frls_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/flash_record_log_store.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_ready  in_action, in_node_value, in_heading_value
// out_      output     out_valid/out_ready out_found, out_node_out, out_heading_out,
//                                         out_slot_index, out_sector_erased
// cfg_      input      cfg_wr_en          cfg_wr_data (magic word)
//
// A save ends in a registered result: the record is written
// to the lowest empty slot in the cycle it is accepted. A load walks the record memory
// from the newest slot down, one read per cycle, as the record memory has a single read
// port. Since records always fill the sector from slot 0 upward, a fill count stands
// for the per-slot written flags, so reset needs no clearing pass and a full-sector
// erase is a count reload. One transaction is in work at a time; a finished result
// waits in the output register while the next transaction is taken.

module flash_record_log_store
  import frls_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [NODE_W-1:0]    in_node_value,
  input  logic [HEADING_W-1:0] in_heading_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [NODE_W-1:0]    out_node_out,
  output logic [HEADING_W-1:0] out_heading_out,
  output logic [SLOT_W-1:0]    out_slot_index,
  output logic                 out_sector_erased,
  input  logic                 cfg_wr_en,
  input  logic [MAGIC_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [MAGIC_W-1:0] magic_value_r, magic_value_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_addr_r, chk_addr_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  rec_t               mem_wdata;
  logic               mem_re;
  rec_t               mem_rdata;

  logic               in_fire;
  logic               full;
  logic [CNT_W-1:0]   fill_m1;

  frls_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOT_COUNT),
    .ADDR_W(IDX_W)
  ) u_rec_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(scan_addr_r),
    .rd_data(mem_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (fill_r == FULL_CNT);
  assign fill_m1  = fill_r - 1'b1;

  assign mem_waddr       = full ? '0 : fill_r[IDX_W-1:0];
  assign mem_wdata.magic   = magic_value_r;
  assign mem_wdata.node    = in_node_value;
  assign mem_wdata.heading = in_heading_value;
  assign mem_we          = in_fire && (in_action == ACT_SAVE);
  assign mem_re          = (state_r == ST_SCAN) && !issue_done_r;

  always_comb begin
    state_nxt       = state_r;
    magic_value_nxt = cfg_wr_en ? cfg_wr_data : magic_value_r;
    fill_nxt        = fill_r;
    scan_addr_nxt   = scan_addr_r;
    issue_done_nxt  = issue_done_r;
    chk_vld_nxt     = 1'b0;
    chk_addr_nxt    = chk_addr_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          if (in_action == ACT_SAVE) begin
            // A full sector is erased by restarting the fill count at slot 0.
            fill_nxt              = full ? CNT_W'(1) : fill_r + 1'b1;
            res_nxt.slot_index    = slot_tag(32'(mem_waddr));
            res_nxt.sector_erased = full;
            state_nxt             = ST_DONE;
          end else if (fill_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            scan_addr_nxt  = fill_m1[IDX_W-1:0];
            issue_done_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued one per cycle, newest slot first; each compare runs in the
        // cycle after its read. Memory is never written while a scan runs.
        if (!issue_done_r) begin
          chk_vld_nxt   = 1'b1;
          chk_addr_nxt  = scan_addr_r;
          scan_addr_nxt = scan_addr_r - 1'b1;
          if (scan_addr_r == '0) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (chk_vld_r) begin
          if (mem_rdata.magic == magic_value_r) begin
            res_nxt.found       = 1'b1;
            res_nxt.node_out    = mem_rdata.node;
            res_nxt.heading_out = mem_rdata.heading;
            res_nxt.slot_index  = slot_tag(32'(chk_addr_r));
            chk_vld_nxt         = 1'b0;
            state_nxt           = ST_DONE;
          end else if (chk_addr_r == '0) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      magic_value_r <= '0;
      fill_r        <= '0;
      issue_done_r  <= 1'b0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      magic_value_r <= magic_value_nxt;
      fill_r        <= fill_nxt;
      issue_done_r  <= issue_done_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_r.found;
  assign out_node_out      = out_r.node_out;
  assign out_heading_out   = out_r.heading_out;
  assign out_slot_index    = out_r.slot_index;
  assign out_sector_erased = out_r.sector_erased;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond sector size");

  a_save_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_SAVE) |=>
      (fill_r == (($past(fill_r) == FULL_CNT) ? CNT_W'(1) : $past(fill_r) + 1'b1)))
    else $error("save did not advance the fill count");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_we)
    else $error("record memory written outside idle");

  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == ST_SCAN))
    else $error("read compare pending outside a scan");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import frls_pkg::*;

  localparam int SLOTS      = SLOT_COUNT_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 2000;
  localparam int TAIL_WAIT  = SLOTS + 16;
  localparam int PHASE_LEN  = 190;

  // Tracks the sector contents and the replies still owed by the block.
  class sector_model;
    bit                   used [SLOTS];
    logic [NODE_W-1:0]    node_mem [SLOTS];
    logic [HEADING_W-1:0] heading_mem [SLOTS];
    logic [MAGIC_W-1:0]   magic_mem [SLOTS];
    logic [MAGIC_W-1:0]   magic;
    res_t                 replies_due [$];
    int                   errors;

    function new();
      magic  = '0;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void note_request(logic act, logic [NODE_W-1:0] node,
                               logic [HEADING_W-1:0] heading);
      res_t r;
      int   slot;
      bit   have_room;
      r         = '0;
      slot      = 0;
      have_room = 1'b0;
      if (act == ACT_SAVE) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!used[i] && !have_room) begin
            slot      = i;
            have_room = 1'b1;
          end
        end
        if (!have_room) begin
          // A full sector is wiped before the record lands in slot 0.
          foreach (used[i]) used[i] = 1'b0;
          slot            = 0;
          r.sector_erased = 1'b1;
        end
        used[slot]        = 1'b1;
        node_mem[slot]    = node;
        heading_mem[slot] = heading;
        magic_mem[slot]   = magic;
        r.slot_index      = slot[SLOT_W-1:0];
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (used[i] && magic_mem[i] == magic && !r.found) begin
            r.found       = 1'b1;
            r.node_out    = node_mem[i];
            r.heading_out = heading_mem[i];
            r.slot_index  = i[SLOT_W-1:0];
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
      end
    endfunction

    function void check_reply(res_t got);
      res_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
      end else begin
        want = replies_due.pop_front();
        compare_field("found", 32'(want.found), 32'(got.found));
        compare_field("node_out", 32'(want.node_out), 32'(got.node_out));
        compare_field("heading_out", 32'(want.heading_out), 32'(got.heading_out));
        compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
        compare_field("sector_erased", 32'(want.sector_erased),
                      32'(got.sector_erased));
      end
    endfunction
  endclass

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic                 in_action         = ACT_SAVE;
  logic [NODE_W-1:0]    in_node_value     = '0;
  logic [HEADING_W-1:0] in_heading_value  = '0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic                 out_found;
  logic [NODE_W-1:0]    out_node_out;
  logic [HEADING_W-1:0] out_heading_out;
  logic [SLOT_W-1:0]    out_slot_index;
  logic                 out_sector_erased;
  logic                 cfg_wr_en         = 1'b0;
  logic [MAGIC_W-1:0]   cfg_wr_data       = '0;

  sector_model log_model;
  bit          send_burst   = 1'b0;
  bit          recv_burst   = 1'b0;
  bit          hold_out     = 1'b0;
  int          quiet_cycles = 0;

  flash_record_log_store DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_node_value     (in_node_value),
    .in_heading_value  (in_heading_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_node_out      (out_node_out),
    .out_heading_out   (out_heading_out),
    .out_slot_index    (out_slot_index),
    .out_sector_erased (out_sector_erased),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [NODE_W-1:0] node,
                           logic [HEADING_W-1:0] heading);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_node_value    <= node;
    in_heading_value <= heading;
    do @(posedge clk); while (!(in_valid && in_ready));
    log_model.note_request(act, node, heading);
  endtask

  // Stops offering transactions until every owed reply has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (log_model.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_magic(logic [MAGIC_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    log_model.magic = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int count, bit with_hold);
    logic act;
    for (int n = 0; n < count; n++) begin
      // Mostly saves, so the sector fills and wraps during the run.
      act = ($urandom_range(0, 9) < 7) ? ACT_SAVE : ACT_LOAD;
      if (with_hold && n == count / 2) hold_out = 1'b1;
      send_item(act, NODE_W'($urandom_range(0, 16'hFFFF)),
                HEADING_W'($urandom_range(0, 8'hFF)));
    end
  endtask

  initial begin : reply_sink
    int   stall;
    res_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 8);
      if (hold_out) begin
        stall    = HOLD_LEN;
        hold_out = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got.found         = out_found;
      got.node_out      = out_node_out;
      got.heading_out   = out_heading_out;
      got.slot_index    = out_slot_index;
      got.sector_erased = out_sector_erased;
      log_model.check_reply(got);
    end
  end

  initial begin : stimulus
    logic [MAGIC_W-1:0] first_magic;
    logic [MAGIC_W-1:0] second_magic;
    log_model = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An erased sector must not match, even with the reset magic of zero.
    send_item(ACT_LOAD, 16'h0000, 8'h00);
    send_item(ACT_SAVE, 16'h0000, 8'h00);
    send_item(ACT_SAVE, 16'hFFFF, 8'hFF);
    send_item(ACT_SAVE, 16'h5A3C, 8'h96);
    send_item(ACT_LOAD, 16'hFFFF, 8'hFF);
    send_item(ACT_SAVE, 16'h8001, 8'h7E);
    send_item(ACT_LOAD, 16'h0000, 8'h00);
    wait_drained();

    // Records saved under magic zero are stale once the magic changes.
    set_magic('1);
    send_item(ACT_LOAD, 16'h1111, 8'h11);
    send_item(ACT_SAVE, 16'hA5A5, 8'hC3);
    send_item(ACT_LOAD, 16'h0000, 8'h00);
    wait_drained();

    // Going back to zero makes the older records visible again.
    set_magic('0);
    send_item(ACT_LOAD, 16'h0000, 8'h00);
    send_item(ACT_SAVE, 16'h1234, 8'h01);
    send_item(ACT_LOAD, 16'h0000, 8'h00);
    wait_drained();

    first_magic = $urandom;
    set_magic(first_magic);
    send_item(ACT_LOAD, 16'h0000, 8'h00);
    send_item(ACT_SAVE, 16'h00FF, 8'h80);
    send_item(ACT_LOAD, 16'hFFFF, 8'hFF);

    random_phase(PHASE_LEN, 1'b0);
    wait_drained();
    set_magic('0);
    random_phase(PHASE_LEN, 1'b1);
    wait_drained();
    set_magic('1);
    random_phase(PHASE_LEN, 1'b0);
    wait_drained();
    second_magic = $urandom;
    set_magic(second_magic);
    random_phase(PHASE_LEN, 1'b1);
    wait_drained();
    set_magic(first_magic);
    random_phase(PHASE_LEN, 1'b0);
    wait_drained();
    set_magic($urandom);
    random_phase(PHASE_LEN, 1'b0);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);
    if (log_model.errors == 0 && log_model.replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
